// ===== rtl/bpb_pkg.sv =====
package bpb_pkg;

  // Input request: one price sample
  typedef struct packed {
    logic signed [23:0] sample;
    logic               series_start;
  } in_t;

  // Result request
  typedef struct packed {
    logic signed [31:0] percent_b;
    logic               width_zero;
  } out_t;

  // Register indexes (byte address = 4 * index)
  typedef enum logic [1:0] {
    REG_PERIOD = 2'd0,
    REG_DEV_UP = 2'd1,
    REG_DEV_DN = 2'd2
  } reg_idx_t;

  localparam int unsigned SQRT_FRAC = 28;
  localparam int unsigned DEV_FRAC  = 12;
  localparam int unsigned RES_FRAC  = 16;
  localparam int unsigned MAG_W     = 17;   // magnitude of a multiplier or their sum

  localparam logic [8:0]  PERIOD_RST = 9'd5;
  localparam logic [15:0] DEV_RST    = 16'd8192;
  localparam logic [31:0] HALF_Q16   = 32'h0000_8000;
  localparam logic [31:0] SAT_POS    = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG    = 32'h8000_0000;

  // Sequencer states
  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_READ = 12'b0000_0000_0010,
    S_SQ   = 12'b0000_0000_0100,
    S_UPD  = 12'b0000_0000_1000,
    S_PREP = 12'b0000_0001_0000,
    S_MUL  = 12'b0000_0010_0000,
    S_DIFF = 12'b0000_0100_0000,
    S_SQRT = 12'b0000_1000_0000,
    S_BW   = 12'b0001_0000_0000,
    S_NUM  = 12'b0010_0000_0000,
    S_DIV  = 12'b0100_0000_0000,
    S_OUT  = 12'b1000_0000_0000
  } state_t;

endpackage

// ===== rtl/bpb_ring.sv =====
module bpb_ring #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned ADDR_W = 8,
  parameter int unsigned DATA_W = 24
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // Write the newest sample
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read of the sample leaving the window
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/bollinger_percent_b_top.sv =====
// Channel  | Ports                          | Moves
// input    | in_valid, in_stall, in_data    | one sample request (sample, series_start)
// output   | out_valid, out_stall, out_data | one %B request (percent_b, width_zero)
// config   | psel..pready                   | period, dev_up, dev_dn at 0x0, 0x4, 0x8
//
// One item at a time. A sample that leaves the window still filling passes through
// S_READ, S_SQ and S_UPD only. One with a result also runs the bit-serial multiplies,
// the two-bits-a-step square root and the one-bit-a-step long division.
// Reset is synchronous; no clearing pass is needed.
// A new sample is taken while a finished result waits in the output register;
// the following result then holds until out_stall drops.
module bollinger_percent_b_top #(
  parameter int unsigned WINDOW_MAX  = 256,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  bpb_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output bpb_pkg::out_t out_data,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import bpb_pkg::*;

  localparam int unsigned SB   = SAMPLE_BITS;
  localparam int unsigned AW   = $clog2(WINDOW_MAX);
  localparam int unsigned LN   = $clog2(WINDOW_MAX + 1);
  localparam int unsigned SW   = SB + LN;
  localparam int unsigned QW   = 2 * SB - 1 + LN;
  localparam int unsigned DW   = 2 * SW;
  localparam int unsigned RDW  = DW + 2 * SQRT_FRAC;
  localparam int unsigned RW   = RDW / 2;
  localparam int unsigned RMW  = RW + 2;
  localparam int unsigned PW   = RW + MAG_W;
  localparam int unsigned NMW  = PW + 1;
  localparam int unsigned NW   = NMW + RES_FRAC + 2;
  localparam int unsigned DENW = PW + 1;
  localparam int unsigned REMW = DENW + 1;
  localparam int unsigned QBW  = 33;
  localparam int unsigned CW   = $clog2(NW + 1);
  localparam int unsigned PCW  = (LN > 9) ? LN : 9;
  localparam int unsigned AMS  = DEV_FRAC + SQRT_FRAC;

  state_t state_r;
  logic [CW-1:0] cnt_r;

  logic [8:0]         period_r;
  logic signed [15:0] dev_up_r;
  logic signed [15:0] dev_dn_r;

  logic signed [SW-1:0] sum_r;
  logic [QW-1:0]        sq_r;
  logic [LN-1:0]        fill_r;
  logic [AW-1:0]        wp_r;

  logic signed [SB-1:0] x_r;
  logic [2*SB-1:0]      xsq_r;
  logic [2*SB-1:0]      osq_r;
  logic signed [SW:0]   dev_r;

  logic [DW-1:0] m1_cand_r, m2_cand_r, acc1_r, acc2_r;
  logic [SW-1:0] m1_plier_r, m2_plier_r;

  logic [RDW-1:0] rad_r;
  logic [RW-1:0]  root_r;
  logic [RMW-1:0] srem_r;

  logic [PW-1:0]    bw_cand_r, b_acc_r, w_acc_r;
  logic [MAG_W-1:0] b_plier_r, w_plier_r;

  logic [NW-1:0]   dvd_r;
  logic [DENW-1:0] den_r;
  logic [REMW-1:0] drem_r;
  logic [QBW-1:0]  q_r;
  logic            ovf_r;
  logic            neg_r;
  logic            wz_r;

  logic out_valid_r;
  out_t out_data_r;

  // Effective period
  logic [PCW-1:0] pe;
  logic [LN-1:0]  p;
  always_comb begin
    pe = PCW'(period_r);
    if (pe == '0) begin
      p = LN'(1);
    end else if (pe > PCW'(WINDOW_MAX)) begin
      p = LN'(WINDOW_MAX);
    end else begin
      p = pe[LN-1:0];
    end
  end

  // Ring index of the sample leaving the window
  logic [LN:0] wp_ext, old_ext;
  logic [AW-1:0] old_idx;
  always_comb begin
    wp_ext = (LN + 1)'(wp_r);
    if (wp_ext >= (LN + 1)'(p)) begin
      old_ext = wp_ext - (LN + 1)'(p);
    end else begin
      old_ext = wp_ext + (LN + 1)'(WINDOW_MAX) - (LN + 1)'(p);
    end
    old_idx = old_ext[AW-1:0];
  end

  logic [SB-1:0] ring_rdata;
  logic signed [SB-1:0] old_s;
  assign old_s = ring_rdata;

  bpb_ring #(
    .DEPTH  (WINDOW_MAX),
    .ADDR_W (AW),
    .DATA_W (SB)
  ) u_ring (
    .clk   (clk),
    .we    (state_r == S_UPD),
    .waddr (wp_r),
    .wdata (x_r),
    .re    (state_r == S_READ),
    .raddr (old_idx),
    .rdata (ring_rdata)
  );

  // Window update
  logic                 full;
  logic signed [SW-1:0] sum_nxt;
  logic [QW-1:0]        sq_nxt;
  logic [LN-1:0]        fill_nxt;
  logic [AW-1:0]        wp_nxt;
  always_comb begin
    full     = (fill_r >= p);
    sum_nxt  = sum_r + SW'(x_r) - (full ? SW'(old_s) : '0);
    sq_nxt   = sq_r + QW'(xsq_r) - (full ? QW'(osq_r) : '0);
    fill_nxt = full ? fill_r : fill_r + LN'(1);
    wp_nxt   = (wp_r == AW'(WINDOW_MAX - 1)) ? '0 : wp_r + AW'(1);
  end

  // Deviation of the newest sample, magnitude of the sum
  logic signed [LN:0] p_s;
  logic signed [SW:0] nx;
  logic [SW-1:0]      smag;
  logic [SW:0]        devmag;
  assign p_s    = signed'({1'b0, p});
  assign nx     = p_s * x_r;
  assign smag   = sum_r[SW-1] ? SW'(-sum_r) : SW'(sum_r);
  assign devmag = dev_r[SW] ? (SW + 1)'(-dev_r) : (SW + 1)'(dev_r);

  // Band multipliers
  logic signed [MAG_W-1:0] dn_ext, band;
  logic [MAG_W-1:0] dn_mag, band_mag;
  assign dn_ext   = MAG_W'(dev_dn_r);
  assign band     = MAG_W'(dev_up_r) + MAG_W'(dev_dn_r);
  assign dn_mag   = dn_ext[MAG_W-1] ? MAG_W'(-dn_ext) : MAG_W'(dn_ext);
  assign band_mag = band[MAG_W-1] ? MAG_W'(-band) : MAG_W'(band);

  // Variance term
  logic [DW-1:0] d_val;
  assign d_val = (acc1_r > acc2_r) ? acc1_r - acc2_r : '0;

  // Square root step
  logic [RMW+1:0] st, strial;
  assign st     = {srem_r, rad_r[RDW-1 -: 2]};
  assign strial = (RMW + 2)'({root_r, 2'b01});

  // Numerator
  logic [NMW-1:0] amag, bmag, nm;
  logic           sa, sb, sn;
  always_comb begin
    amag = NMW'(devmag) << AMS;
    bmag = NMW'(b_acc_r);
    sa   = dev_r[SW];
    sb   = dev_dn_r[15];
    if (sa == sb) begin
      nm = amag + bmag;
      sn = sa;
    end else if (amag >= bmag) begin
      nm = amag - bmag;
      sn = sa;
    end else begin
      nm = bmag - amag;
      sn = sb;
    end
  end

  // Division step
  logic [REMW-1:0] dt;
  logic            dge;
  assign dt  = {drem_r[REMW-2:0], dvd_r[NW-1]};
  assign dge = (dt >= REMW'(den_r));

  // Saturated result
  logic [31:0] res;
  always_comb begin
    if (wz_r) begin
      res = HALF_Q16;
    end else if (neg_r) begin
      res = (ovf_r || q_r > QBW'(SAT_NEG)) ? SAT_NEG : 32'(-q_r[31:0]);
    end else begin
      res = (ovf_r || q_r > QBW'(SAT_POS)) ? SAT_POS : q_r[31:0];
    end
  end

  logic in_acc, cfg_wr, out_free, last;
  assign in_acc   = in_valid && !in_stall;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign out_free = !out_valid_r || !out_stall;
  assign last     = (cnt_r == CW'(1));

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RST;
      dev_up_r <= DEV_RST;
      dev_dn_r <= DEV_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_PERIOD: period_r <= pwdata[8:0];
        REG_DEV_UP: dev_up_r <= pwdata[15:0];
        REG_DEV_DN: dev_dn_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (paddr[3:2])
      REG_PERIOD: prdata = 32'(period_r);
      REG_DEV_UP: prdata = 32'(dev_up_r);
      REG_DEV_DN: prdata = 32'(dev_dn_r);
      default:    prdata = '0;
    endcase
  end
  assign pready = 1'b1;

  // Window state and sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sum_r       <= '0;
      sq_r        <= '0;
      fill_r      <= '0;
      wp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // drop a taken result unless the next one is loaded in the same cycle
      if (out_valid_r && !out_stall && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr && paddr[3:2] == REG_PERIOD) begin
        sum_r  <= '0;
        sq_r   <= '0;
        fill_r <= '0;
        wp_r   <= '0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            x_r <= in_data.sample[SB-1:0];
            if (in_data.series_start) begin
              sum_r  <= '0;
              sq_r   <= '0;
              fill_r <= '0;
              wp_r   <= '0;
            end
            state_r <= S_READ;
          end
        end
        S_READ: begin
          xsq_r   <= x_r * x_r;
          state_r <= S_SQ;
        end
        S_SQ: begin
          osq_r   <= old_s * old_s;
          state_r <= S_UPD;
        end
        S_UPD: begin
          sum_r  <= sum_nxt;
          sq_r   <= sq_nxt;
          fill_r <= fill_nxt;
          wp_r   <= wp_nxt;
          state_r <= (fill_nxt >= p) ? S_PREP : S_IDLE;
        end
        S_PREP: begin
          dev_r      <= nx - (SW + 1)'(sum_r);
          m1_cand_r  <= DW'(sq_r);
          m1_plier_r <= SW'(p);
          m2_cand_r  <= DW'(smag);
          m2_plier_r <= smag;
          acc1_r     <= '0;
          acc2_r     <= '0;
          cnt_r      <= CW'(SW);
          state_r    <= S_MUL;
        end
        S_MUL: begin
          // shift-and-add: n * Q and S * S together
          if (m1_plier_r[0]) acc1_r <= acc1_r + m1_cand_r;
          if (m2_plier_r[0]) acc2_r <= acc2_r + m2_cand_r;
          m1_cand_r  <= m1_cand_r << 1;
          m2_cand_r  <= m2_cand_r << 1;
          m1_plier_r <= m1_plier_r >> 1;
          m2_plier_r <= m2_plier_r >> 1;
          cnt_r      <= cnt_r - CW'(1);
          if (last) state_r <= S_DIFF;
        end
        S_DIFF: begin
          if (band == '0 || d_val == '0) begin
            wz_r    <= 1'b1;
            state_r <= S_OUT;
          end else begin
            wz_r    <= 1'b0;
            rad_r   <= {d_val, {(2 * SQRT_FRAC){1'b0}}};
            root_r  <= '0;
            srem_r  <= '0;
            cnt_r   <= CW'(RW);
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          // two radicand bits a step
          if (st >= strial) begin
            srem_r <= RMW'(st - strial);
            root_r <= {root_r[RW-2:0], 1'b1};
          end else begin
            srem_r <= RMW'(st);
            root_r <= {root_r[RW-2:0], 1'b0};
          end
          rad_r <= rad_r << 2;
          if (last) begin
            state_r <= S_BW;
            cnt_r   <= CW'(MAG_W);
          end else begin
            cnt_r <= cnt_r - CW'(1);
          end
          bw_cand_r <= '0;
          b_acc_r   <= '0;
          w_acc_r   <= '0;
          b_plier_r <= dn_mag;
          w_plier_r <= band_mag;
        end
        S_BW: begin
          // load the root on entry, then shift-and-add dev_dn * r and band * r
          if (cnt_r == CW'(MAG_W) && bw_cand_r == '0) begin
            bw_cand_r <= PW'(root_r);
          end else begin
            if (b_plier_r[0]) b_acc_r <= b_acc_r + bw_cand_r;
            if (w_plier_r[0]) w_acc_r <= w_acc_r + bw_cand_r;
            bw_cand_r <= bw_cand_r << 1;
            b_plier_r <= b_plier_r >> 1;
            w_plier_r <= w_plier_r >> 1;
            cnt_r     <= cnt_r - CW'(1);
            if (last) state_r <= S_NUM;
          end
        end
        S_NUM: begin
          dvd_r   <= (NW'(nm) << (RES_FRAC + 1)) + NW'(w_acc_r);
          den_r   <= {w_acc_r, 1'b0};
          drem_r  <= '0;
          q_r     <= '0;
          ovf_r   <= 1'b0;
          neg_r   <= sn ^ band[MAG_W-1];
          cnt_r   <= CW'(NW);
          state_r <= S_DIV;
        end
        S_DIV: begin
          // one quotient bit a step, overflow kept sticky
          drem_r <= dge ? dt - REMW'(den_r) : dt;
          q_r    <= {q_r[QBW-2:0], dge};
          ovf_r  <= ovf_r | q_r[QBW-1];
          dvd_r  <= dvd_r << 1;
          cnt_r  <= cnt_r - CW'(1);
          if (last) state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_data_r.percent_b  <= res;
            out_data_r.width_zero <= wz_r;
            out_valid_r           <= 1'b1;
            state_r               <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/bpb_checker.sv =====
module bpb_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input bpb_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input bpb_pkg::out_t out_data
);
  import bpb_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // One sample at a time: busy after each request taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second sample taken while busy");

  // Zero width always gives one half
  a_half: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.width_zero |-> out_data.percent_b == HALF_Q16)
    else $error("zero width without 0.5");

  // Drop results on reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind bollinger_percent_b_top bpb_checker u_bpb_checker (.*);
